// File: sv/mie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the extended Euclidean modular inverse block.
// Holds the default width, the controller state type and the command and
// status structs that pass between controller and datapath. No dependencies.
package mie_pkg;

	localparam int DEFAULT_WIDTH = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_FINISH
	} mie_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture a new operand pair
		logic div_init;  // clear the divider for the next Euclid step
		logic div_step;  // one quotient bit of the division
		logic update;    // shift remainders and coefficients
		logic emit;      // move the result into the output register
	} mie_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic r1_zero;   // current divisor is zero, the algorithm is done
		logic div_last;  // the division is on its last bit
		logic out_free;  // the output register can take a result
	} mie_stat_t;

endpackage
`default_nettype wire

// File: sv/mie_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Input channel of the modular inverse block: valid, ready and the operand pair.
// Depends on mie_pkg for the default width.
interface mie_in_if #(
	parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] value;
	logic [WIDTH-1:0] modulus;

	modport source (output valid, output value, output modulus, input ready);
	modport sink (input valid, input value, input modulus, output ready);
endinterface
`default_nettype wire

// File: sv/mie_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Output channel of the modular inverse block: valid, ready and the result.
// Depends on mie_pkg for the default width.
interface mie_out_if #(
	parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
);
	logic             valid;
	logic             ready;
	logic [WIDTH-1:0] inverse;
	logic             has_inverse;

	modport source (output valid, output inverse, output has_inverse, input ready);
	modport sink (input valid, input inverse, input has_inverse, output ready);
endinterface
`default_nettype wire

// File: sv/mie_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller state machine of the modular inverse block.
// Depends on mie_pkg for the state type and the command and status structs.
module mie_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire mie_pkg::mie_stat_t stat,
	output mie_pkg::mie_cmd_t      cmd
);

	mie_pkg::mie_state_t state_q;
	mie_pkg::mie_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mie_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mie_pkg::ST_IDLE: begin
				if (in_valid) state_d = mie_pkg::ST_CHECK;
			end
			mie_pkg::ST_CHECK: begin
				state_d = stat.r1_zero ? mie_pkg::ST_FINISH : mie_pkg::ST_DIV;
			end
			mie_pkg::ST_DIV: begin
				if (stat.div_last) state_d = mie_pkg::ST_UPDATE;
			end
			mie_pkg::ST_UPDATE: begin
				state_d = mie_pkg::ST_CHECK;
			end
			mie_pkg::ST_FINISH: begin
				if (stat.out_free) state_d = mie_pkg::ST_IDLE;
			end
			default: begin
				state_d = mie_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mie_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			mie_pkg::ST_CHECK: begin
				cmd.div_init = !stat.r1_zero;
			end
			mie_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			mie_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
			end
			mie_pkg::ST_FINISH: begin
				cmd.emit = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/mie_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the modular inverse block: remainders, sign-magnitude
// coefficients, a bit-serial divider and the output register.
// Depends on mie_pkg for the command and status structs.
module mie_dp #(
	parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mie_pkg::mie_cmd_t  cmd,
	output mie_pkg::mie_stat_t      stat,
	input  wire logic [WIDTH-1:0]   value,
	input  wire logic [WIDTH-1:0]   modulus,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [WIDTH-1:0]        inverse,
	output logic                    has_inverse
);

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	// Euclid state: r0/r1 remainders, s0/s1 coefficients of value.
	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] r0_q;
	logic [WIDTH-1:0] r1_q;
	logic             s0_neg_q;
	logic [WIDTH-1:0] s0_mag_q;
	logic             s1_neg_q;
	logic [WIDTH-1:0] s1_mag_q;

	// Divider: shifting dividend, partial remainder, running q*|s1|.
	logic [WIDTH-1:0] dq_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH:0]   p_q;
	logic [CW-1:0]    cnt_q;

	logic [WIDTH-1:0] inverse_q;
	logic             has_inverse_q;
	logic             out_valid_q;

	logic [WIDTH:0]   rem_sh;
	logic             qbit;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH:0]   p_next;

	logic             pneg;
	logic [WIDTH+1:0] x_ext;
	logic [WIDTH+1:0] p_ext;
	logic [WIDTH+1:0] mag_calc;
	logic             sn_neg;
	logic [WIDTH-1:0] sn_mag;
	logic [WIDTH-1:0] inv_calc;

	// One restoring division step per cycle, quotient bits MSB first.
	always_comb begin
		rem_sh   = {rem_q, dq_q[WIDTH-1]};
		qbit     = rem_sh >= {1'b0, r1_q};
		rem_next = qbit ? WIDTH'(rem_sh - {1'b0, r1_q}) : rem_sh[WIDTH-1:0];
		p_next   = {p_q[WIDTH-1:0], 1'b0} + (qbit ? {1'b0, s1_mag_q} : '0);
	end

	// New coefficient s0 - q*s1 in sign-magnitude form.
	always_comb begin
		pneg  = s1_neg_q && (p_q != '0);
		x_ext = {2'b00, s0_mag_q};
		p_ext = {1'b0, p_q};
		mag_calc = x_ext;
		sn_neg   = s0_neg_q;
		if (p_q == '0) begin
			mag_calc = x_ext;
			sn_neg   = s0_neg_q;
		end else if (s0_mag_q == '0 || s0_neg_q != pneg) begin
			mag_calc = x_ext + p_ext;
			sn_neg   = (s0_mag_q == '0) ? !pneg : s0_neg_q;
		end else if (x_ext >= p_ext) begin
			mag_calc = x_ext - p_ext;
			sn_neg   = s0_neg_q && (mag_calc != '0);
		end else begin
			mag_calc = p_ext - x_ext;
			sn_neg   = !s0_neg_q;
		end
		sn_mag = mag_calc[WIDTH-1:0];
	end

	// A negative coefficient is brought into range by adding the modulus.
	assign inv_calc = (s0_neg_q && s0_mag_q != '0) ? WIDTH'(mod_q - s0_mag_q) : s0_mag_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mod_q    <= modulus;
			r0_q     <= value;
			r1_q     <= modulus;
			s0_neg_q <= 1'b0;
			s0_mag_q <= WIDTH'(1);
			s1_neg_q <= 1'b0;
			s1_mag_q <= '0;
		end else if (cmd.update) begin
			r0_q     <= r1_q;
			r1_q     <= rem_q;
			s0_neg_q <= s1_neg_q;
			s0_mag_q <= s1_mag_q;
			s1_neg_q <= sn_neg;
			s1_mag_q <= sn_mag;
		end

		if (cmd.div_init) begin
			dq_q  <= r0_q;
			rem_q <= '0;
			p_q   <= '0;
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
			p_q   <= p_next;
		end

		if (cmd.emit) begin
			inverse_q     <= inv_calc;
			has_inverse_q <= (r0_q == WIDTH'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.r1_zero  = (r1_q == '0);
	assign stat.div_last = (cnt_q == CW'(WIDTH - 1));
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign inverse     = inverse_q;
	assign has_inverse = has_inverse_q;

endmodule
`default_nettype wire

// File: sv/modular_inverse_ext_euclid.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the modular inverse block (extended Euclidean algorithm).
// Depends on mie_pkg, mie_in_if, mie_out_if, mie_ctrl and mie_dp.
//
// Channel   Direction  Payload
// in_ch     sink       value, modulus (WIDTH bits each, unsigned)
// out_ch    source     inverse (WIDTH bits, unsigned), has_inverse (1 bit)
//
// One operand pair is worked on at a time. Each Euclid step consists of one
// check of the divisor, a run of the bit-serial divider and one update of
// remainders and coefficients. After the last step the result is loaded into
// the output register, and the controller returns to idle before it takes
// the next pair.
// Reset clears the controller and the output valid flag; there is no state
// between transactions. A result waits in the output register while out_ch
// stalls, and a new input transaction is taken as soon as the controller is
// idle again, so one result can wait while the next pair is processed.
module modular_inverse_ext_euclid #(
	parameter int WIDTH = mie_pkg::DEFAULT_WIDTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mie_in_if.sink    in_ch,
	mie_out_if.source out_ch
);

	mie_pkg::mie_cmd_t  cmd;
	mie_pkg::mie_stat_t stat;
	logic               in_ready;

	// The controller sequences check, divide and update steps until the
	// divisor reaches zero, then hands the result to the output register.
	mie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the remainders, the coefficients of value in
	// sign-magnitude form and the divider, which also accumulates q * |s1|
	// so the coefficient update needs no multiplier.
	mie_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.value       (in_ch.value),
		.modulus     (in_ch.modulus),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.inverse     (out_ch.inverse),
		.has_inverse (out_ch.has_inverse)
	);

	assign in_ch.ready = in_ready;

endmodule
`default_nettype wire
